// File: design/dlb_pkg.sv
// Package: widths, constants and shared types of the daily light budget controller.
`timescale 1ns / 1ps
package dlb_pkg;

	localparam int COUNT_BITS_DEF = 18;

	localparam int THRESH_W   = 7;
	localparam int HOUR_W     = 5;
	localparam int MIN_W      = 17;
	localparam int DOY_W      = 9;
	localparam int LEVEL_W    = 7;
	localparam int MS_W       = 32;
	localparam int NAT_W      = 18;
	localparam int TOTAL_W    = 19;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 17;

	// ms to whole seconds: floor(x / 1000) == (x * RECIP) >> 38 for any 32-bit x
	localparam int RECIP_W  = 29;
	localparam int MS_SHIFT = 38;
	localparam int SECS_W   = MS_W + RECIP_W - MS_SHIFT;
	localparam logic [RECIP_W-1:0] MS_RECIP = 29'd274877907;

	localparam logic [DOY_W-1:0] DAY_WRAP = 9'd365;
	localparam logic [DOY_W-1:0] DAY_NONE = 9'd511;

	localparam logic [THRESH_W-1:0] THRESH_RST = 7'd50;
	localparam logic [HOUR_W-1:0]   START_RST  = 5'd6;
	localparam logic [MIN_W-1:0]    MIN_RST    = 17'd43200;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_THRESH = 2'd0,
		CFG_START  = 2'd1,
		CFG_MIN    = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [THRESH_W-1:0] thresh;
		logic [HOUR_W-1:0]   start_hour;
		logic [MIN_W-1:0]    min_secs;
	} cfg_t;

	typedef struct packed {
		logic            time_ok;
		logic            is_day;
		logic            light_ok;
		logic            bright;
		logic            clear;
		logic [MS_W-1:0] elapsed;
	} front_t;

	typedef struct packed {
		logic              time_ok;
		logic              is_day;
		logic              light_ok;
		logic              bright;
		logic              clear;
		logic [SECS_W-1:0] secs;
	} tick_t;

endpackage

// File: design/dlb_if.sv
// Interfaces: tick input, result output and configuration write channels.
`timescale 1ns / 1ps
interface dlb_in_if;
	logic                         valid;
	logic                         ready;
	logic                         time_ok;
	logic [dlb_pkg::DOY_W-1:0]    day_of_year;
	logic [dlb_pkg::HOUR_W-1:0]   hour_of_day;
	logic                         is_day;
	logic                         light_ok;
	logic [dlb_pkg::LEVEL_W-1:0]  light_level;
	logic [dlb_pkg::MS_W-1:0]     now_ms;

	modport source (output valid, time_ok, day_of_year, hour_of_day, is_day, light_ok,
		light_level, now_ms, input ready);
	modport sink (input valid, time_ok, day_of_year, hour_of_day, is_day, light_ok,
		light_level, now_ms, output ready);
endinterface

interface dlb_out_if;
	logic                         valid;
	logic                         ready;
	logic                         lamp_on;
	logic [dlb_pkg::NAT_W-1:0]    natural_secs;
	logic [dlb_pkg::NAT_W-1:0]    supplement_secs;
	logic [dlb_pkg::TOTAL_W-1:0]  total_secs;
	logic                         clock_ok;

	modport source (output valid, lamp_on, natural_secs, supplement_secs, total_secs,
		clock_ok, input ready);
	modport sink (input valid, lamp_on, natural_secs, supplement_secs, total_secs,
		clock_ok, output ready);
endinterface

interface dlb_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [dlb_pkg::CFG_IDX_W-1:0]  index;
	logic [dlb_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: design/daily_light_budget_controller_unit.sv
// Top level of the daily light budget controller.
//
//   channel    dir  handshake       carries
//   item_in    in   valid/ready     time_ok, day_of_year, hour_of_day, is_day,
//                                   light_ok, light_level, now_ms
//   item_out   out  valid/ready     lamp_on, natural_secs, supplement_secs,
//                                   total_secs, clock_ok
//   cfg_wr     in   valid/ready     index, data (always ready)
//
// From accept to result an item passes the input register, the seconds multiply and the counter update.
// One item per cycle sustained while item_out is ready; the counter/LED update feeds back from its own registers.
// Reset clears counters, stamp, day key and LED, and loads config defaults.
// A stall on item_out holds the result and backs up through the stages to item_in.ready.
`timescale 1ns / 1ps
module daily_light_budget_controller_unit #(
	parameter int COUNT_BITS = dlb_pkg::COUNT_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	dlb_in_if.sink      item_in,
	dlb_out_if.source   item_out,
	dlb_cfg_if.sink     cfg_wr
);
	dlb_pkg::cfg_t   cfg;
	logic            valid_s1;
	dlb_pkg::front_t front_s1;
	logic            div_ready;
	logic            valid_s2;
	dlb_pkg::tick_t  tick_s2;
	logic            cnt_ready;

	dlb_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg_wr (cfg_wr),
		.cfg    (cfg)
	);

	dlb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_in    (item_in),
		.cfg        (cfg),
		.down_ready (div_ready),
		.valid_s1   (valid_s1),
		.front_s1   (front_s1)
	);

	dlb_div u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s1   (valid_s1),
		.front_s1   (front_s1),
		.down_ready (cnt_ready),
		.up_ready   (div_ready),
		.valid_s2   (valid_s2),
		.tick_s2    (tick_s2)
	);

	dlb_count #(
		.COUNT_BITS (COUNT_BITS)
	) u_count (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s2 (valid_s2),
		.tick_s2  (tick_s2),
		.cfg      (cfg),
		.up_ready (cnt_ready),
		.item_out (item_out)
	);
endmodule

// File: design/dlb_cfg.sv
// Configuration register file: threshold, day start hour, minimum light seconds.
`timescale 1ns / 1ps
module dlb_cfg (
	input  logic            clk,
	input  logic            arst_n,
	dlb_cfg_if.sink         cfg_wr,
	output dlb_pkg::cfg_t   cfg
);
	dlb_pkg::cfg_t cfg_q;

	assign cfg_wr.ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.thresh     <= dlb_pkg::THRESH_RST;
			cfg_q.start_hour <= dlb_pkg::START_RST;
			cfg_q.min_secs   <= dlb_pkg::MIN_RST;
		end else if (cfg_wr.valid) begin
			unique case (cfg_wr.index)
				dlb_pkg::CFG_THRESH: cfg_q.thresh     <= cfg_wr.data[dlb_pkg::THRESH_W-1:0];
				dlb_pkg::CFG_START:  cfg_q.start_hour <= cfg_wr.data[dlb_pkg::HOUR_W-1:0];
				dlb_pkg::CFG_MIN:    cfg_q.min_secs   <= cfg_wr.data[dlb_pkg::MIN_W-1:0];
				default: ;
			endcase
		end
	end
endmodule

// File: design/dlb_front.sv
// Input stage: light-cycle day key, day change detect, ms stamp tracking, input register.
`timescale 1ns / 1ps
module dlb_front (
	input  logic             clk,
	input  logic             arst_n,
	dlb_in_if.sink           item_in,
	input  dlb_pkg::cfg_t    cfg,
	input  logic             down_ready,
	output logic             valid_s1,
	output dlb_pkg::front_t  front_s1
);
	logic [dlb_pkg::MS_W-1:0]  stamp_q;
	logic [dlb_pkg::DOY_W-1:0] day_q;
	logic                      seen_q;

	logic                      accept;
	logic [dlb_pkg::DOY_W-1:0] key;
	logic                      new_day;
	dlb_pkg::front_t           front_d;

	assign item_in.ready = !valid_s1 || down_ready;
	assign accept = item_in.valid && item_in.ready;

	always_comb begin
		if (item_in.hour_of_day < cfg.start_hour) begin
			key = (item_in.day_of_year == '0) ? dlb_pkg::DAY_WRAP
				: item_in.day_of_year - dlb_pkg::DOY_W'(1);
		end else begin
			key = item_in.day_of_year;
		end
		new_day = !seen_q || (key != day_q);

		front_d.time_ok  = item_in.time_ok;
		front_d.is_day   = item_in.is_day;
		front_d.light_ok = item_in.light_ok;
		front_d.bright   = item_in.light_ok && (item_in.light_level >= cfg.thresh);
		front_d.clear    = item_in.time_ok && new_day;
		// zero stamp only starts timing; a new day restarts it
		front_d.elapsed  = (item_in.time_ok && !new_day && stamp_q != '0)
			? item_in.now_ms - stamp_q : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			stamp_q  <= '0;
			day_q    <= dlb_pkg::DAY_NONE;
			seen_q   <= 1'b0;
		end else begin
			if (item_in.ready) begin
				valid_s1 <= item_in.valid;
			end
			if (accept && item_in.time_ok) begin
				stamp_q <= item_in.now_ms;
				day_q   <= key;
				seen_q  <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			front_s1 <= front_d;
		end
	end
endmodule

// File: design/dlb_div.sv
// Seconds stage: elapsed ms to whole seconds by reciprocal multiply, registered.
`timescale 1ns / 1ps
module dlb_div (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid_s1,
	input  dlb_pkg::front_t  front_s1,
	input  logic             down_ready,
	output logic             up_ready,
	output logic             valid_s2,
	output dlb_pkg::tick_t   tick_s2
);
	localparam int PROD_W = dlb_pkg::MS_W + dlb_pkg::RECIP_W;

	logic [PROD_W-1:0] prod;
	dlb_pkg::tick_t    tick_d;

	assign up_ready = !valid_s2 || down_ready;

	assign prod = PROD_W'(front_s1.elapsed) * PROD_W'(dlb_pkg::MS_RECIP);

	always_comb begin
		tick_d.time_ok  = front_s1.time_ok;
		tick_d.is_day   = front_s1.is_day;
		tick_d.light_ok = front_s1.light_ok;
		tick_d.bright   = front_s1.bright;
		tick_d.clear    = front_s1.clear;
		tick_d.secs     = prod[dlb_pkg::MS_SHIFT +: dlb_pkg::SECS_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (up_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && valid_s1) begin
			tick_s2 <= tick_d;
		end
	end
endmodule

// File: design/dlb_count.sv
// Counter stage: saturating light counters, LED decision and result register.
`timescale 1ns / 1ps
module dlb_count #(
	parameter int COUNT_BITS = dlb_pkg::COUNT_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            valid_s2,
	input  dlb_pkg::tick_t  tick_s2,
	input  dlb_pkg::cfg_t   cfg,
	output logic            up_ready,
	dlb_out_if.source       item_out
);
	localparam int SUM_W = ((COUNT_BITS > dlb_pkg::SECS_W) ? COUNT_BITS : dlb_pkg::SECS_W) + 1;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

	logic                  out_valid_q;
	logic [COUNT_BITS-1:0] nat_q;
	logic [COUNT_BITS-1:0] sup_q;
	logic [COUNT_BITS:0]   total_q;
	logic                  lamp_q;
	logic                  clock_q;

	logic                  advance;
	logic [COUNT_BITS-1:0] nat_base;
	logic [COUNT_BITS-1:0] sup_base;
	logic [SUM_W-1:0]      nat_sum;
	logic [SUM_W-1:0]      sup_sum;
	logic [COUNT_BITS-1:0] nat_d;
	logic [COUNT_BITS-1:0] sup_d;
	logic [COUNT_BITS:0]   total_d;
	logic                  lamp_d;

	assign up_ready = !out_valid_q || item_out.ready;
	assign advance  = up_ready && valid_s2;

	always_comb begin
		nat_base = tick_s2.clear ? '0 : nat_q;
		sup_base = tick_s2.clear ? '0 : sup_q;
		nat_sum  = SUM_W'(nat_base) + SUM_W'(tick_s2.secs);
		sup_sum  = SUM_W'(sup_base) + SUM_W'(tick_s2.secs);

		nat_d = nat_base;
		if (tick_s2.is_day && tick_s2.bright) begin
			nat_d = (nat_sum > SUM_W'(CNT_MAX)) ? CNT_MAX : COUNT_BITS'(nat_sum);
		end
		// supplemental time uses the LED state from before this item
		sup_d = sup_base;
		if (lamp_q) begin
			sup_d = (sup_sum > SUM_W'(CNT_MAX)) ? CNT_MAX : COUNT_BITS'(sup_sum);
		end
		total_d = (COUNT_BITS + 1)'(nat_d) + (COUNT_BITS + 1)'(sup_d);

		priority if (!tick_s2.light_ok) begin
			lamp_d = lamp_q;
		end else if (!tick_s2.time_ok) begin
			lamp_d = 1'b0;
		end else if (tick_s2.is_day) begin
			lamp_d = !tick_s2.bright;
		end else begin
			lamp_d = total_d < (COUNT_BITS + 1)'(cfg.min_secs);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			nat_q       <= '0;
			sup_q       <= '0;
			total_q     <= '0;
			lamp_q      <= 1'b0;
			clock_q     <= 1'b0;
		end else begin
			if (up_ready) begin
				out_valid_q <= valid_s2;
			end
			if (advance) begin
				nat_q   <= nat_d;
				sup_q   <= sup_d;
				total_q <= total_d;
				lamp_q  <= lamp_d;
				clock_q <= tick_s2.time_ok;
			end
		end
	end

	assign item_out.valid           = out_valid_q;
	assign item_out.lamp_on         = lamp_q;
	assign item_out.natural_secs    = dlb_pkg::NAT_W'(nat_q);
	assign item_out.supplement_secs = dlb_pkg::NAT_W'(sup_q);
	assign item_out.total_secs      = dlb_pkg::TOTAL_W'(total_q);
	assign item_out.clock_ok        = clock_q;
endmodule
